FILE: design/pid_controller_clamped_assert.svh
// Assertion macros shared by the controller modules.
`ifndef PID_CONTROLLER_CLAMPED_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_ASSERT_SVH
`ifndef SYNTHESIS
`define PIDC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PIDC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PIDC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PIDC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: design/pidc_pkg.sv
// Shared types, constants, microcode table and arithmetic helpers of the PID controller.
package pidc_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int MAGQ_W    = PROD_W - FRAC_W;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = 4;
  localparam int COND_W    = 2;
  localparam int PC_W      = 5;
  localparam int DIV_CNT_W = $clog2(DATA_W);

  localparam logic signed [DATA_W-1:0] V_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] V_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_MIN  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_MAX  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX    = CFG_IDX_W'(6);

  localparam logic [OP_W-1:0] OP_ERR      = OP_W'(0);
  localparam logic [OP_W-1:0] OP_MUL_P    = OP_W'(1);
  localparam logic [OP_W-1:0] OP_SAT_P    = OP_W'(2);
  localparam logic [OP_W-1:0] OP_MUL_I    = OP_W'(3);
  localparam logic [OP_W-1:0] OP_SAT_T    = OP_W'(4);
  localparam logic [OP_W-1:0] OP_MUL_T    = OP_W'(5);
  localparam logic [OP_W-1:0] OP_IADD     = OP_W'(6);
  localparam logic [OP_W-1:0] OP_ICLAMP   = OP_W'(7);
  localparam logic [OP_W-1:0] OP_DE       = OP_W'(8);
  localparam logic [OP_W-1:0] OP_MUL_D    = OP_W'(9);
  localparam logic [OP_W-1:0] OP_DIV_INIT = OP_W'(10);
  localparam logic [OP_W-1:0] OP_DIV_STEP = OP_W'(11);
  localparam logic [OP_W-1:0] OP_SAT_D    = OP_W'(12);
  localparam logic [OP_W-1:0] OP_SUM      = OP_W'(13);
  localparam logic [OP_W-1:0] OP_OCLAMP   = OP_W'(14);
  localparam logic [OP_W-1:0] OP_DONE     = OP_W'(15);

  localparam logic [COND_W-1:0] COND_NONE     = COND_W'(0);
  localparam logic [COND_W-1:0] COND_DIV_MORE = COND_W'(1);
  localparam logic [COND_W-1:0] COND_OUT_WAIT = COND_W'(2);

  localparam logic [PC_W-1:0] PC_START = PC_W'(0);
  localparam logic [PC_W-1:0] PC_DIV   = PC_W'(12);
  localparam logic [PC_W-1:0] PC_DONE  = PC_W'(16);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DATA_W - 1);

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
    logic              last;
  } uword_t;

  typedef struct packed {
    logic            en;
    logic [OP_W-1:0] op;
  } ctrl_t;

  typedef struct packed {
    logic div_more;
    logic out_full;
  } stat_t;

  function automatic uword_t pidc_ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{OP_DONE, COND_NONE, PC_START, 1'b1};
    case (pc)
      PC_W'(0):  w = '{OP_ERR,      COND_NONE,     PC_START, 1'b0};
      PC_W'(1):  w = '{OP_MUL_P,    COND_NONE,     PC_START, 1'b0};
      PC_W'(2):  w = '{OP_SAT_P,    COND_NONE,     PC_START, 1'b0};
      PC_W'(3):  w = '{OP_MUL_I,    COND_NONE,     PC_START, 1'b0};
      PC_W'(4):  w = '{OP_SAT_T,    COND_NONE,     PC_START, 1'b0};
      PC_W'(5):  w = '{OP_MUL_T,    COND_NONE,     PC_START, 1'b0};
      PC_W'(6):  w = '{OP_SAT_T,    COND_NONE,     PC_START, 1'b0};
      PC_W'(7):  w = '{OP_IADD,     COND_NONE,     PC_START, 1'b0};
      PC_W'(8):  w = '{OP_ICLAMP,   COND_NONE,     PC_START, 1'b0};
      PC_W'(9):  w = '{OP_DE,       COND_NONE,     PC_START, 1'b0};
      PC_W'(10): w = '{OP_MUL_D,    COND_NONE,     PC_START, 1'b0};
      PC_W'(11): w = '{OP_DIV_INIT, COND_NONE,     PC_START, 1'b0};
      PC_W'(12): w = '{OP_DIV_STEP, COND_DIV_MORE, PC_DIV,   1'b0};
      PC_W'(13): w = '{OP_SAT_D,    COND_NONE,     PC_START, 1'b0};
      PC_W'(14): w = '{OP_SUM,      COND_NONE,     PC_START, 1'b0};
      PC_W'(15): w = '{OP_OCLAMP,   COND_NONE,     PC_START, 1'b0};
      PC_W'(16): w = '{OP_DONE,     COND_OUT_WAIT, PC_DONE,  1'b1};
      default:   w = '{OP_DONE,     COND_NONE,     PC_START, 1'b1};
    endcase
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] u;
    u = v;
    return v[DATA_W-1] ? (~u + DATA_W'(1)) : u;
  endfunction

  function automatic logic [DATA_W:0] mag33(input logic signed [DATA_W:0] v);
    logic [DATA_W:0] u;
    u = v;
    return v[DATA_W] ? (~u + (DATA_W+1)'(1)) : u;
  endfunction

  // saturate a sign-magnitude value to the signed word range
  function automatic logic signed [DATA_W-1:0] sat_mag(input logic neg,
                                                       input logic [MAGQ_W-1:0] m);
    logic [MAGQ_W-1:0] lim;
    logic [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] r;
    lim = {{(MAGQ_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}} + MAGQ_W'(neg);
    lo  = m[DATA_W-1:0];
    if (m > lim) begin
      r = neg ? V_MIN : V_MAX;
    end else begin
      r = neg ? (~lo + DATA_W'(1)) : lo;
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? V_MIN : V_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] v);
    logic signed [DATA_W-1:0] r;
    if ((v[DATA_W+1] != v[DATA_W]) || (v[DATA_W] != v[DATA_W-1])) begin
      r = v[DATA_W+1] ? V_MIN : V_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/pidc_in_if.sv
// Input channel: measured value, target, time step and clamp enables.
interface pidc_in_if;
  import pidc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] measured;
  logic signed [DATA_W-1:0] target;
  logic [DATA_W-1:0]        step_time;
  logic                     integ_clamp_on;
  logic                     out_clamp_on;
  modport source (output valid, measured, target, step_time, integ_clamp_on, out_clamp_on,
                  input ready);
  modport sink (input valid, measured, target, step_time, integ_clamp_on, out_clamp_on,
                output ready);
endinterface

FILE: design/pidc_out_if.sv
// Result channel: drive value and clamp flags.
interface pidc_out_if;
  import pidc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  logic                     integ_clamped;
  logic                     out_clamped;
  modport source (output valid, drive, integ_clamped, out_clamped, input ready);
  modport sink (input valid, drive, integ_clamped, out_clamped, output ready);
endinterface

FILE: design/pidc_cfg_if.sv
// Configuration write channel: register index and write data.
interface pidc_cfg_if;
  import pidc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/pidc_sequencer.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`include "pid_controller_clamped_assert.svh"
module pidc_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  pidc_pkg::stat_t stat,
  output pidc_pkg::ctrl_t ctrl,
  output logic            busy
);
  import pidc_pkg::*;

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  uword_t          uw;
  logic            take_jump;

  assign uw        = pidc_ucode(pc_r);
  assign ctrl.en   = busy_r;
  assign ctrl.op   = uw.op;
  assign busy      = busy_r;

  always_comb begin
    case (uw.cond)
      COND_NONE:     take_jump = 1'b0;
      COND_DIV_MORE: take_jump = stat.div_more;
      COND_OUT_WAIT: take_jump = stat.out_full;
      default:       take_jump = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = PC_START;
    end else if (busy_r) begin
      if (take_jump) begin
        pc_nxt = uw.target;
      end else if (uw.last) begin
        busy_nxt = 1'b0;
        pc_nxt   = PC_START;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= PC_START;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  `PIDC_ASSERT(a_start_busy, clk, rst_n, start |=> busy_r, "sequencer did not start")
  `PIDC_ASSERT(a_idle_pc, clk, rst_n, !busy_r |-> pc_r == PC_START, "idle with pc away from start")
  `PIDC_ASSERT(a_last_ends, clk, rst_n, (busy_r && uw.last && !stat.out_full) |=> !busy_r, "program did not end")
  `PIDC_ASSERT_NEVER(a_start_busy_overlap, clk, rst_n, start && busy_r, "start while busy")

endmodule

FILE: design/pidc_datapath.sv
// Datapath: config registers, state, shared multiplier, divider step and clamps.
module pidc_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pidc_pkg::ctrl_t                    ctrl,
  output pidc_pkg::stat_t                    stat,
  input  logic                               start,
  input  logic signed [pidc_pkg::DATA_W-1:0] measured,
  input  logic signed [pidc_pkg::DATA_W-1:0] target,
  input  logic [pidc_pkg::DATA_W-1:0]        step_time,
  input  logic                               integ_clamp_on,
  input  logic                               out_clamp_on,
  input  logic                               cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [pidc_pkg::DATA_W-1:0]        cfg_data,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [pidc_pkg::DATA_W-1:0] out_drive,
  output logic                               out_iflag,
  output logic                               out_oflag
);
  import pidc_pkg::*;

  logic signed [DATA_W-1:0] kp_r, ki_r, kd_r, imin_r, imax_r, omin_r, omax_r;
  logic signed [DATA_W-1:0] integ_r, last_err_r;
  logic signed [DATA_W-1:0] meas_r, tgt_r;
  logic [DATA_W-1:0]        dt_r;
  logic                     ic_on_r, oc_on_r;
  logic signed [DATA_W-1:0] e_r, up_r, t_r, ud_r, drive_r;
  logic signed [DATA_W:0]   de_r, ui_r;
  logic signed [DATA_W+1:0] u_r;
  logic [PROD_W-1:0]        prod_r;
  logic                     neg_r, ovf_r, iflag_r, oflag_r;
  logic [DATA_W-1:0]        rem_r, quot_r;
  logic [DIV_CNT_W-1:0]     div_cnt_r;
  logic                     out_valid_r, out_iflag_r, out_oflag_r;
  logic signed [DATA_W-1:0] out_drive_r;

  logic [DATA_W-1:0]        mul_a;
  logic [DATA_W:0]          mul_b;
  logic [PROD_W:0]          mul_p;
  logic signed [DATA_W-1:0] satq;
  logic [DATA_W-1:0]        div_d;
  logic [DATA_W:0]          trial, trial_sub;
  logic                     trial_ge;
  logic signed [DATA_W:0]   diff_in, imin_x, imax_x;
  logic signed [DATA_W+1:0] omin_x, omax_x;
  logic                     out_full, exec;

  assign exec     = ctrl.en;
  assign out_full = out_valid_r && !out_ready;
  assign stat.out_full = out_full;
  assign stat.div_more = div_cnt_r != DIV_LAST;

  always_comb begin
    case (ctrl.op)
      OP_MUL_P: begin
        mul_a = mag32(kp_r);
        mul_b = {1'b0, mag32(e_r)};
      end
      OP_MUL_I: begin
        mul_a = mag32(ki_r);
        mul_b = {1'b0, mag32(e_r)};
      end
      OP_MUL_T: begin
        mul_a = mag32(t_r);
        mul_b = {1'b0, dt_r};
      end
      default: begin
        mul_a = mag32(kd_r);
        mul_b = mag33(de_r);
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign satq      = sat_mag(neg_r, prod_r[PROD_W-1:FRAC_W]);
  assign div_d     = (dt_r == '0) ? DATA_W'(1) : dt_r;
  assign trial     = {rem_r, quot_r[DATA_W-1]};
  assign trial_ge  = trial >= {1'b0, div_d};
  assign trial_sub = trial - {1'b0, div_d};
  assign diff_in   = {tgt_r[DATA_W-1], tgt_r} - {meas_r[DATA_W-1], meas_r};
  assign imin_x    = {imin_r[DATA_W-1], imin_r};
  assign imax_x    = {imax_r[DATA_W-1], imax_r};
  assign omin_x    = {{2{omin_r[DATA_W-1]}}, omin_r};
  assign omax_x    = {{2{omax_r[DATA_W-1]}}, omax_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      imin_r <= '0;
      imax_r <= '0;
      omin_r <= '0;
      omax_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PROP_GAIN:  kp_r   <= cfg_data;
        REG_INTEG_GAIN: ki_r   <= cfg_data;
        REG_DERIV_GAIN: kd_r   <= cfg_data;
        REG_INTEG_MIN:  imin_r <= cfg_data;
        REG_INTEG_MAX:  imax_r <= cfg_data;
        REG_OUT_MIN:    omin_r <= cfg_data;
        REG_OUT_MAX:    omax_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      meas_r  <= measured;
      tgt_r   <= target;
      dt_r    <= step_time;
      ic_on_r <= integ_clamp_on;
      oc_on_r <= out_clamp_on;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      last_err_r <= '0;
    end else if (exec) begin
      case (ctrl.op)
        OP_ICLAMP: begin
          if (ic_on_r && (ui_r > imax_x)) begin
            integ_r <= imax_r;
          end else if (ic_on_r && (ui_r < imin_x)) begin
            integ_r <= imin_r;
          end else begin
            integ_r <= sat33(ui_r);
          end
        end
        OP_OCLAMP: last_err_r <= e_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      case (ctrl.op)
        OP_ERR: e_r <= sat33(diff_in);
        OP_MUL_P: begin
          prod_r <= mul_p[PROD_W-1:0];
          neg_r  <= kp_r[DATA_W-1] ^ e_r[DATA_W-1];
        end
        OP_SAT_P: up_r <= satq;
        OP_MUL_I: begin
          prod_r <= mul_p[PROD_W-1:0];
          neg_r  <= ki_r[DATA_W-1] ^ e_r[DATA_W-1];
        end
        OP_SAT_T: t_r <= satq;
        OP_MUL_T: begin
          prod_r <= mul_p[PROD_W-1:0];
          neg_r  <= t_r[DATA_W-1];
        end
        OP_IADD: ui_r <= {integ_r[DATA_W-1], integ_r} + {t_r[DATA_W-1], t_r};
        OP_ICLAMP: iflag_r <= ic_on_r && ((ui_r > imax_x) || (ui_r < imin_x));
        OP_DE: de_r <= {e_r[DATA_W-1], e_r} - {last_err_r[DATA_W-1], last_err_r};
        OP_MUL_D: begin
          prod_r <= mul_p[PROD_W-1:0];
          neg_r  <= kd_r[DATA_W-1] ^ de_r[DATA_W];
        end
        OP_DIV_INIT: begin
          ovf_r     <= prod_r[PROD_W-1:DATA_W] >= div_d;
          rem_r     <= prod_r[PROD_W-1:DATA_W];
          quot_r    <= prod_r[DATA_W-1:0];
          div_cnt_r <= '0;
        end
        OP_DIV_STEP: begin
          rem_r     <= trial_ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
          quot_r    <= {quot_r[DATA_W-2:0], trial_ge};
          div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
        end
        OP_SAT_D: begin
          if (ovf_r) begin
            ud_r <= neg_r ? V_MIN : V_MAX;
          end else begin
            ud_r <= sat_mag(neg_r, {{(MAGQ_W-DATA_W){1'b0}}, quot_r});
          end
        end
        OP_SUM: u_r <= {{2{up_r[DATA_W-1]}}, up_r} + {{2{integ_r[DATA_W-1]}}, integ_r}
                     + {{2{ud_r[DATA_W-1]}}, ud_r};
        OP_OCLAMP: begin
          if (oc_on_r && (u_r > omax_x)) begin
            drive_r <= omax_r;
            oflag_r <= 1'b1;
          end else if (oc_on_r && (u_r < omin_x)) begin
            drive_r <= omin_r;
            oflag_r <= 1'b1;
          end else begin
            drive_r <= sat34(u_r);
            oflag_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec && (ctrl.op == OP_DONE) && !out_full) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && (ctrl.op == OP_DONE) && !out_full) begin
      out_drive_r <= drive_r;
      out_iflag_r <= iflag_r;
      out_oflag_r <= oflag_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;
  assign out_iflag = out_iflag_r;
  assign out_oflag = out_oflag_r;

endmodule

FILE: design/pid_controller_clamped.sv
// Positional PID controller with integrator and output clamps, Q16.16.
//
// Channels: in_ch takes one control step (measured, target, step_time and
// two clamp enables); out_ch returns the drive value with integ_clamped and
// out_clamped flags; cfg_ch writes gains and limits by index and is always
// ready. Write configuration only while no step is in flight.
// Each step runs a 17-word microprogram over one shared multiplier; the
// derivative division takes one quotient bit per cycle.
// The result word is loaded into the output register by the final microword.
// A new step is accepted only once the previous one has ended; in_ch.ready
// is high while no step is running.
// Reset (rst_n low, synchronous) clears gains, limits, integrator and last
// error to zero and empties the output register.
// A stalled receiver is held off by the output register: the next step runs
// up to its final microword and waits there until the register frees up.
`include "pid_controller_clamped_assert.svh"
module pid_controller_clamped (
  input  logic       clk,
  input  logic       rst_n,
  pidc_in_if.sink    in_ch,
  pidc_out_if.source out_ch,
  pidc_cfg_if.sink   cfg_ch
);
  import pidc_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  busy;
  logic  start;
  logic  out_stall;

  assign in_ch.ready  = !busy;
  assign cfg_ch.ready = 1'b1;
  assign start        = in_ch.valid && !busy;
  assign out_stall    = out_ch.valid && !out_ch.ready;

  pidc_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  pidc_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .start          (start),
    .measured       (in_ch.measured),
    .target         (in_ch.target),
    .step_time      (in_ch.step_time),
    .integ_clamp_on (in_ch.integ_clamp_on),
    .out_clamp_on   (in_ch.out_clamp_on),
    .cfg_we         (cfg_ch.valid),
    .cfg_idx        (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_drive      (out_ch.drive),
    .out_iflag      (out_ch.integ_clamped),
    .out_oflag      (out_ch.out_clamped)
  );

  `PIDC_ASSERT(a_accept_blocks, clk, rst_n, start |=> !in_ch.ready, "accepted a word while running")
  `PIDC_ASSERT(a_out_needs_run, clk, rst_n, $rose(out_ch.valid) |-> $past(busy), "result without a step")
  `PIDC_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_ch.valid, "word lost")
  `PIDC_ASSERT(a_out_stable, clk, rst_n, out_stall |=> $stable(out_ch.drive), "word changed")

endmodule
